@@ hdl/bvpd_pkg.sv @@
// Package: beat types, decode codes and accumulator state for the poll response decoder.
`default_nettype none

package bvpd_pkg;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       is_last;
        logic       is_empty_ack;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] routing;
        logic [3:0] bill_type;
        logic [5:0] error_bits;
        logic [2:0] status_bits;
        logic       reenable_request;
    } out_beat_t;

    typedef struct packed {
        logic [2:0] routing;
        logic [3:0] bill_type;
        logic [5:0] errors;
        logic [2:0] status;
        logic       reenable;
    } acc_t;

    localparam logic [2:0] ROUTE_NONE     = 3'd0;
    localparam logic [2:0] ROUTE_STACKED  = 3'd1;
    localparam logic [2:0] ROUTE_ESCROW   = 3'd2;
    localparam logic [2:0] ROUTE_RETURNED = 3'd3;
    localparam logic [2:0] ROUTE_REJECTED = 3'd4;
    localparam logic [2:0] ROUTE_RECYCLER = 3'd5;

    localparam logic [2:0] RCODE_STACKED  = 3'd0;
    localparam logic [2:0] RCODE_ESCROW   = 3'd1;
    localparam logic [2:0] RCODE_RETURNED = 3'd2;
    localparam logic [2:0] RCODE_RECYCLER = 3'd3;
    localparam logic [2:0] RCODE_REJECTED = 3'd4;

    localparam logic [3:0] RC_MOTOR    = 4'h6;
    localparam logic [3:0] RC_ROM      = 4'h8;
    localparam logic [3:0] RC_REENABLE = 4'h9;

    localparam logic [3:0] VS_MOTOR    = 4'h1;
    localparam logic [3:0] VS_SENSOR   = 4'h2;
    localparam logic [3:0] VS_BUSY     = 4'h3;
    localparam logic [3:0] VS_ROM      = 4'h4;
    localparam logic [3:0] VS_JAM      = 4'h5;
    localparam logic [3:0] VS_RESET    = 4'h6;
    localparam logic [3:0] VS_CASHBOX  = 4'h8;
    localparam logic [3:0] VS_DISABLED = 4'h9;
    localparam logic [3:0] VS_REMOVAL  = 4'hC;

    localparam int ERR_MOTOR   = 0;
    localparam int ERR_SENSOR  = 1;
    localparam int ERR_ROM     = 2;
    localparam int ERR_JAM     = 3;
    localparam int ERR_CASHBOX = 4;
    localparam int ERR_REMOVAL = 5;

    localparam int ST_BUSY     = 0;
    localparam int ST_RESET    = 1;
    localparam int ST_DISABLED = 2;

endpackage

`default_nettype wire

@@ hdl/bill_validator_poll_decode.sv @@
// Top level: registered bill validator poll response decoder.
//
//   channel  direction  handshake              beat type
//   in       input      in_valid / in_ready    bvpd_pkg::in_beat_t
//   out      output     out_valid / out_ready  bvpd_pkg::out_beat_t
//
// One beat per cycle sustained unless an ending beat stalls; a beat waits in the
// input register, is decoded into the accumulators and, on the last byte or an
// empty acknowledge, shows on out the cycle after from the output register.
// Reset clears the accumulators, the sticky bill type and both valid flags.
// A waiting result stalls only the next ending beat: hold it in the input register
// and drop in_ready until out is taken; non-ending beats keep advancing meanwhile.
`default_nettype none

module bill_validator_poll_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bvpd_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bvpd_pkg::out_beat_t out_data
);
    import bvpd_pkg::*;

    logic      in_vld_reg;
    in_beat_t  in_beat_reg;
    acc_t      acc_reg;
    acc_t      acc_next;
    logic      mid_reg;
    logic      mid_next;
    logic      emit;
    logic      advance;
    logic      out_vld_reg;
    logic      out_vld_next;
    out_beat_t out_beat_reg;

    bvpd_decode u_decode (
        .beat         (in_beat_reg),
        .acc          (acc_reg),
        .mid_response (mid_reg),
        .acc_next     (acc_next),
        .mid_next     (mid_next),
        .emit         (emit)
    );

    assign advance  = in_vld_reg && (!emit || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        out_vld_next = out_vld_reg && !out_ready;
        if (advance && emit)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mid_reg     <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                acc_reg <= acc_next;
                mid_reg <= mid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_beat_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_beat_reg.routing          <= acc_next.routing;
            out_beat_reg.bill_type        <= acc_next.bill_type;
            out_beat_reg.error_bits       <= acc_next.errors;
            out_beat_reg.status_bits      <= acc_next.status;
            out_beat_reg.reenable_request <= acc_next.reenable;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> out_vld_reg)
        else $error("ending beat gave no result");

    a_end_clears_mid: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> !mid_reg)
        else $error("response still open after its result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |-> !(advance && emit))
        else $error("waiting result overwritten");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_beat_reg))
        else $error("stalled input beat lost");

    a_routing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_beat_reg.routing <= ROUTE_RECYCLER))
        else $error("routing code out of range");

endmodule

`default_nettype wire

@@ hdl/bvpd_decode.sv @@
// Byte decoder: next accumulator state and end-of-response flag for one beat.
`default_nettype none

module bvpd_decode (
    input  bvpd_pkg::in_beat_t beat,
    input  bvpd_pkg::acc_t     acc,
    input  logic               mid_response,
    output bvpd_pkg::acc_t     acc_next,
    output logic               mid_next,
    output logic               emit
);
    import bvpd_pkg::*;

    acc_t       base;
    logic [3:0] lo;
    logic [2:0] code;

    assign lo   = beat.resp_byte[3:0];
    assign code = beat.resp_byte[6:4];

    always_comb
    begin
        base = acc;
        if (beat.is_empty_ack || !mid_response)
        begin
            base.routing  = ROUTE_NONE;
            base.errors   = '0;
            base.status   = '0;
            base.reenable = 1'b0;
        end

        acc_next = base;
        if (beat.is_empty_ack)
        begin
            mid_next = 1'b0;
            emit     = 1'b1;
        end
        else
        begin
            mid_next = !beat.is_last;
            emit     = beat.is_last;
            if (beat.resp_byte[7])
            begin
                unique case (code)
                    RCODE_STACKED:  acc_next.routing = ROUTE_STACKED;
                    RCODE_ESCROW:
                    begin
                        acc_next.routing   = ROUTE_ESCROW;
                        acc_next.bill_type = lo;
                    end
                    RCODE_RETURNED: acc_next.routing = ROUTE_RETURNED;
                    RCODE_RECYCLER: acc_next.routing = ROUTE_RECYCLER;
                    RCODE_REJECTED: acc_next.routing = ROUTE_REJECTED;
                    default:        acc_next.routing = ROUTE_NONE;
                endcase
            end
            else if (beat.resp_byte[5])
            begin
                unique case (lo)
                    RC_MOTOR:    acc_next.errors[ERR_MOTOR] = 1'b1;
                    RC_ROM:      acc_next.errors[ERR_ROM]   = 1'b1;
                    RC_REENABLE: acc_next.reenable          = 1'b1;
                    default:     acc_next.reenable          = base.reenable;
                endcase
            end
            else
            begin
                unique case (lo)
                    VS_MOTOR:    acc_next.errors[ERR_MOTOR]    = 1'b1;
                    VS_SENSOR:   acc_next.errors[ERR_SENSOR]   = 1'b1;
                    VS_BUSY:     acc_next.status[ST_BUSY]      = 1'b1;
                    VS_ROM:      acc_next.errors[ERR_ROM]      = 1'b1;
                    VS_JAM:      acc_next.errors[ERR_JAM]      = 1'b1;
                    VS_RESET:    acc_next.status[ST_RESET]     = 1'b1;
                    VS_CASHBOX:  acc_next.errors[ERR_CASHBOX]  = 1'b1;
                    VS_DISABLED: acc_next.status[ST_DISABLED]  = 1'b1;
                    VS_REMOVAL:  acc_next.errors[ERR_REMOVAL]  = 1'b1;
                    default:     acc_next.status               = base.status;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
